// ===== design/cas_pkg.sv =====
// Shared types, constants and helpers for the cave smoothing core.
// Used by the window cells and the top level; no dependencies.
package cas_pkg;

    localparam int MAX_WIDTH = 128;
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int W_W       = X_W + 1;
    localparam int TILE_W    = 8;
    localparam int Y_W       = 10;
    localparam int THR_W     = 4;
    localparam int WALLS_W   = 4;
    localparam int REG_W     = 3;

    localparam logic [Y_W-1:0] MAX_HEIGHT = 10'd1023;
    localparam int             MIN_DIM    = 3;

    // register indexes on the configuration port
    localparam logic [REG_W-1:0] REG_MAP_WIDTH      = 3'd0;
    localparam logic [REG_W-1:0] REG_MAP_HEIGHT     = 3'd1;
    localparam logic [REG_W-1:0] REG_CAVE_TOP_ROW   = 3'd2;
    localparam logic [REG_W-1:0] REG_WALL_CODE      = 3'd3;
    localparam logic [REG_W-1:0] REG_FLOOR_CODE     = 3'd4;
    localparam logic [REG_W-1:0] REG_WALL_THRESHOLD = 3'd5;

    localparam logic [7:0]        RST_MAP_WIDTH      = 8'd128;
    localparam logic [Y_W-1:0]    RST_MAP_HEIGHT     = 10'd64;
    localparam logic [Y_W-1:0]    RST_CAVE_TOP_ROW   = 10'd18;
    localparam logic [TILE_W-1:0] RST_WALL_CODE      = 8'd1;
    localparam logic [TILE_W-1:0] RST_FLOOR_CODE     = 8'd0;
    localparam logic [THR_W-1:0]  RST_WALL_THRESHOLD = 4'd5;

    // one column of the 3x3 window: row two up, row one up, current row
    typedef struct packed {
        logic [TILE_W-1:0] top;
        logic [TILE_W-1:0] mid;
        logic [TILE_W-1:0] bot;
    } t_col;

    // wall count of one window column, middle tile optional
    function automatic logic [1:0] col_walls(t_col c, logic [TILE_W-1:0] code,
                                             logic count_mid);
        logic [1:0] n;
        n = {1'b0, c.top == code} + {1'b0, c.bot == code}
          + {1'b0, count_mid && (c.mid == code)};
        return n;
    endfunction

endpackage

// ===== design/cas_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are not reset.
module cas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read sees the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cas_cell.sv =====
// One column cell of the smoothing window: holds three tiles, shifts them
// to its neighbor and reports its wall count. Depends on cas_pkg.
module cas_cell
    import cas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  t_col              i_col,
    input  logic [TILE_W-1:0] i_wall_code,
    input  logic              i_count_mid,
    output t_col              o_col,
    output logic [1:0]        o_walls
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col   = r_col;
    assign o_walls = col_walls(r_col, i_wall_code, i_count_mid);

endmodule

// ===== design/cave_automaton_smoothing_core.sv =====
// Cave smoothing core top level: position counters, line stores, window
// cell chain, result sequencing and the APB register file. Uses cas_pkg,
// cas_ram and cas_cell.
//
// One smoothing pass of a neighbor-count threshold cave rule over a raster tile stream. A tile
// yields zero to two result beats, sent one per cycle from an output register
// while the output does not stall. A tile yields two beats at the last column of
// an inner row and at every tile of the bottom row, which also echoes the tile.
// The result sequencer in front of the output register picks each beat.
// The first beat of a tile passes the stage register, then the output register;
// the second beat follows it. The two previous rows sit in 128-entry line stores
// with registered read (plus a copy of the row one up, read at the last column);
// they need no clearing pass after reset.
// The 3x3 window is a chain of two column cells fed by the line stores.
module cave_automaton_smoothing_core
    import cas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // tile input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TILE_W-1:0] i_tile,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [X_W-1:0]    o_cell_x,
    output logic [Y_W-1:0]    o_cell_y,
    output logic [TILE_W-1:0] o_cell_tile,
    output logic              o_frame_last
);

    localparam int CMP_W = (W_W > 8) ? W_W : 8;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [TILE_W-1:0] tile;
        logic              v0;       // first result slot used
        logic              v1;       // second result slot used
        logic              sel_a;    // first slot is the last column of the row above
        logic              slot1_d;  // second slot echoes the bottom row tile
        logic              last1;
        logic              smooth;
        logic [X_W-1:0]    x0;
        logic [Y_W-1:0]    y0;
        logic [X_W-1:0]    x1;
        logic [Y_W-1:0]    y1;
    } t_s1;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [TILE_W-1:0] tile;
        logic              last;
    } t_res;

    // ------------------------------------------------------------------
    // registers
    logic [7:0]        r_map_width;
    logic [Y_W-1:0]    r_map_height;
    logic [Y_W-1:0]    r_cave_top_row;
    logic [TILE_W-1:0] r_wall_code;
    logic [TILE_W-1:0] r_floor_code;
    logic [THR_W-1:0]  r_wall_threshold;

    logic             cfg_we;
    logic [REG_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width      <= RST_MAP_WIDTH;
            r_map_height     <= RST_MAP_HEIGHT;
            r_cave_top_row   <= RST_CAVE_TOP_ROW;
            r_wall_code      <= RST_WALL_CODE;
            r_floor_code     <= RST_FLOOR_CODE;
            r_wall_threshold <= RST_WALL_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MAP_WIDTH:      r_map_width      <= pwdata[7:0];
                REG_MAP_HEIGHT:     r_map_height     <= pwdata[Y_W-1:0];
                REG_CAVE_TOP_ROW:   r_cave_top_row   <= pwdata[Y_W-1:0];
                REG_WALL_CODE:      r_wall_code      <= pwdata[TILE_W-1:0];
                REG_FLOOR_CODE:     r_floor_code     <= pwdata[TILE_W-1:0];
                REG_WALL_THRESHOLD: r_wall_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAP_WIDTH:      prdata = {24'd0, r_map_width};
            REG_MAP_HEIGHT:     prdata = {{(32-Y_W){1'b0}}, r_map_height};
            REG_CAVE_TOP_ROW:   prdata = {{(32-Y_W){1'b0}}, r_cave_top_row};
            REG_WALL_CODE:      prdata = {{(32-TILE_W){1'b0}}, r_wall_code};
            REG_FLOOR_CODE:     prdata = {{(32-TILE_W){1'b0}}, r_floor_code};
            REG_WALL_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, r_wall_threshold};
            default:            prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // map size in use
    logic [CMP_W-1:0] map_w_ext;
    logic [W_W-1:0]   w_eff;
    logic [X_W-1:0]   w_m1;
    logic [Y_W-1:0]   h_eff;
    logic [Y_W-1:0]   h_m1;

    always_comb begin
        map_w_ext = CMP_W'(r_map_width);
        if (map_w_ext < CMP_W'(MIN_DIM)) begin
            w_eff = W_W'(MIN_DIM);
        end else if (map_w_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(map_w_ext);
        end
        w_m1  = X_W'(w_eff - W_W'(1));
        h_eff = (r_map_height < Y_W'(MIN_DIM)) ? Y_W'(MIN_DIM) : r_map_height;
        h_m1  = h_eff - Y_W'(1);
    end

    // ------------------------------------------------------------------
    // handshake and result sequencing
    logic r_s1_valid;
    t_s1  r_s1;
    logic r_phase;
    logic r_out_valid;
    t_res r_out;

    logic pend0, pend1, push, s1_done, accept, out_free;

    assign pend0    = r_s1.v0 && !r_phase;
    assign pend1    = r_s1.v1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign push     = r_s1_valid && (pend0 || pend1) && out_free;
    assign s1_done  = r_s1_valid && (!(pend0 || pend1) || (push && !(pend0 && pend1)));
    assign o_in_stall = r_s1_valid && !s1_done;
    assign accept   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // position of the incoming tile
    logic [X_W-1:0] r_col, n_col, x0;
    logic [Y_W-1:0] r_row, n_row, y0, y_inc, ym1, yn;
    logic [W_W-1:0] xn;
    logic           wrap;

    always_comb begin
        wrap  = {1'b0, r_col} >= w_eff;
        x0    = wrap ? '0 : r_col;
        y_inc = wrap ? r_row + Y_W'(1) : r_row;
        y0    = (y_inc >= h_eff) ? '0 : y_inc;
        ym1   = y0 - Y_W'(1);
        xn    = {1'b0, x0} + W_W'(1);
        yn    = y0 + Y_W'(1);
        if (xn >= w_eff) begin
            n_col = '0;
            n_row = (yn >= h_eff) ? '0 : yn;
        end else begin
            n_col = X_W'(xn);
            n_row = y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // slot decode for the tile being taken
    t_s1  n_s1;
    logic bottom, y_ge1, x_eq0, x_last;

    always_comb begin
        bottom = (y0 == h_m1);
        y_ge1  = (y0 != '0);
        x_eq0  = (x0 == '0);
        x_last = (x0 == w_m1);

        n_s1.x       = x0;
        n_s1.tile    = i_tile;
        n_s1.v0      = y_ge1 && (!x_eq0 || bottom);
        n_s1.v1      = bottom || (y_ge1 && x_last);
        n_s1.sel_a   = x_eq0;
        n_s1.slot1_d = bottom;
        n_s1.last1   = bottom && x_last;
        n_s1.smooth  = (y0 >= Y_W'(2)) && (ym1 > r_cave_top_row) && (x0 >= X_W'(2));
        n_s1.x0      = x_eq0 ? w_m1 : x0 - X_W'(1);
        n_s1.y0      = ym1;
        n_s1.x1      = x0;
        n_s1.y1      = bottom ? y0 : ym1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_phase <= 1'b0;
            end else if (push) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // line stores
    logic [TILE_W-1:0] up1_rd, up2_rd, lastcol_rd;

    cas_ram #(.WIDTH(TILE_W), .DEPTH(MAX_WIDTH)) u_row_one_up (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (x0),
        .i_wdata (i_tile),
        .i_re    (accept),
        .i_raddr (x0),
        .o_rdata (up1_rd)
    );

    // copy of the row one up, read at the last column of the row
    cas_ram #(.WIDTH(TILE_W), .DEPTH(MAX_WIDTH)) u_row_one_up_last (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (x0),
        .i_wdata (i_tile),
        .i_re    (accept),
        .i_raddr (w_m1),
        .o_rdata (lastcol_rd)
    );

    cas_ram #(.WIDTH(TILE_W), .DEPTH(MAX_WIDTH)) u_row_two_up (
        .i_clk   (i_clk),
        .i_we    (s1_done),
        .i_waddr (r_s1.x),
        .i_wdata (up1_rd),
        .i_re    (accept),
        .i_raddr (x0),
        .o_rdata (up2_rd)
    );

    // ------------------------------------------------------------------
    // window: live column from the stores, then two column cells
    t_col       live_col, mid_col, old_col;
    logic [1:0] mid_walls, old_walls;

    assign live_col = '{top: up2_rd, mid: up1_rd, bot: r_s1.tile};

    cas_cell u_cell_mid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (s1_done),
        .i_col       (live_col),
        .i_wall_code (r_wall_code),
        .i_count_mid (1'b0),
        .o_col       (mid_col),
        .o_walls     (mid_walls)
    );

    cas_cell u_cell_old (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (s1_done),
        .i_col       (mid_col),
        .i_wall_code (r_wall_code),
        .i_count_mid (1'b1),
        .o_col       (old_col),
        .o_walls     (old_walls)
    );

    logic [WALLS_W-1:0] walls;
    logic [TILE_W-1:0]  smooth_tile, slot0_tile, slot1_tile;
    t_res               n_out;

    always_comb begin
        walls = WALLS_W'(mid_walls) + WALLS_W'(old_walls)
              + WALLS_W'(col_walls(live_col, r_wall_code, 1'b1));
        if (r_s1.smooth) begin
            smooth_tile = (walls >= r_wall_threshold) ? r_wall_code : r_floor_code;
        end else begin
            smooth_tile = mid_col.mid;
        end
        slot0_tile = r_s1.sel_a ? lastcol_rd : smooth_tile;
        slot1_tile = r_s1.slot1_d ? r_s1.tile : up1_rd;

        if (pend0) begin
            n_out = '{x: r_s1.x0, y: r_s1.y0, tile: slot0_tile, last: 1'b0};
        end else begin
            n_out = '{x: r_s1.x1, y: r_s1.y1, tile: slot1_tile, last: r_s1.last1};
        end
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_x     = r_out.x;
    assign o_cell_y     = r_out.y;
    assign o_cell_tile  = r_out.tile;
    assign o_frame_last = r_out.last;

`ifndef SYNTHESIS
    // second-slot phase only exists while a two-beat tile is held
    a_phase_two_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_s1_valid && r_s1.v0 && r_s1.v1))
        else $error("phase set without a two-beat tile in stage");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted tile lost before the stage register");

    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && !accept) |=> !r_s1_valid)
        else $error("finished tile still held in stage");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("pushed result beat not presented");
`endif

endmodule
